/* hdl/sia_pkg.sv */
package sia_pkg;

  // command codes on in_cmd
  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_GET     = 2'd1;
  localparam logic [1:0] CMD_REL_NUM = 2'd2;
  localparam logic [1:0] CMD_REL_ID  = 2'd3;

  // result status codes on out_status
  localparam logic [1:0] STAT_EXISTS = 2'd0;
  localparam logic [1:0] STAT_NEW    = 2'd1;
  localparam logic [1:0] STAT_NONE   = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  // configuration register indexes
  localparam logic CFG_MIN_ID = 1'b0;
  localparam logic CFG_MAX_ID = 1'b1;

  localparam logic [31:0] MIN_ID_RESET = 32'd0;
  localparam logic [31:0] MAX_ID_RESET = 32'd16;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_REL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

/* hdl/sia_ram.sv */
module sia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/sequential_id_allocator.sv */
// Sequential id allocator. Binds 32-bit external numbers to ids min_id + k, where k is the
// slot index. Commands: lookup (0), get or allocate the lowest free usable slot (1), release
// by number (2) and release by id (3); a full table reports status 3 and binds nothing.
// Usable slots are min(max_id - min_id, SLOTS), none when max_id <= min_id. The numbers live
// in a single-port-read RAM that a sequencer scans one slot per cycle with one shared
// comparator; commands 0 to 2 end the scan at the slot where the number is found or after
// the last slot, while release by id reads no RAM and goes straight to its result. A
// result waits in the done state while out_stall holds the previous result beat in the
// output register. in_stall is high while a command is in progress, including while its
// result waits for the output register. Every slot is free after reset with no clearing
// pass; write min_id and max_id only while the block is idle.
module sequential_id_allocator
  import sia_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  // commands
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_number,
  input  logic [31:0] in_id,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_id_out
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t             state_r, state_nxt;
  logic [31:0]        min_id_r, min_id_nxt;
  logic [31:0]        max_id_r, max_id_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [31:0]        num_r, num_nxt;
  logic [31:0]        id_r, id_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [31:0]        res_id_r, res_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [31:0]        out_id_r, out_id_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [31:0]        ram_rdata;

  logic               accept;
  logic [31:0]        span;
  logic [CNT_W-1:0]   lim_calc;
  logic               hit;
  logic               slot_free;
  logic [31:0]        rel_k;
  logic               rel_hit;

  sia_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_num_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (num_r),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // usable slot count from the current registers
  assign span = max_id_r - min_id_r;
  always_comb begin
    if (max_id_r <= min_id_r) begin
      lim_calc = '0;
    end else if (span < 32'(SLOTS)) begin
      lim_calc = span[CNT_W-1:0];
    end else begin
      lim_calc = CNT_W'(SLOTS);
    end
  end

  // shared comparator on the slot whose data the RAM shows this cycle
  assign hit = valid_r[idx_r] && (ram_rdata == num_r);
  assign slot_free = !valid_r[idx_r] && (CNT_W'(idx_r) < lim_r);

  // release by id: slot index from the id
  assign rel_k = id_r - min_id_r;
  assign rel_hit = (rel_k < 32'(SLOTS)) && valid_r[rel_k[IDX_W-1:0]];

  // RAM read address leads the scan index by one
  assign ram_raddr = (state_r == S_SCAN) ? idx_r + IDX_W'(1) : '0;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    min_id_nxt     = min_id_r;
    max_id_nxt     = max_id_r;
    valid_nxt      = valid_r;
    cmd_nxt        = cmd_r;
    num_nxt        = num_r;
    id_nxt         = id_r;
    lim_nxt        = lim_r;
    idx_nxt        = idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    ram_we         = 1'b0;
    ram_waddr      = free_idx_r;

    if (cfg_we) begin
      if (cfg_idx == CFG_MIN_ID) begin
        min_id_nxt = cfg_data;
      end else begin
        max_id_nxt = cfg_data;
      end
    end

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_cmd;
          num_nxt        = in_number;
          id_nxt         = in_id;
          lim_nxt        = lim_calc;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          state_nxt      = (in_cmd == CMD_REL_ID) ? S_REL : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status_nxt = STAT_EXISTS;
          res_id_nxt     = min_id_r + 32'(idx_r);
          if (cmd_r == CMD_REL_NUM) begin
            valid_nxt[idx_r] = 1'b0;
          end
          state_nxt = S_DONE;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = STAT_NONE;
          res_id_nxt     = '0;
          if (cmd_r == CMD_GET) begin
            if (free_found_r || slot_free) begin
              ram_waddr               = free_found_r ? free_idx_r : idx_r;
              ram_we                  = 1'b1;
              valid_nxt[ram_waddr]    = 1'b1;
              res_status_nxt          = STAT_NEW;
              res_id_nxt              = min_id_r + 32'(ram_waddr);
            end else begin
              res_status_nxt = STAT_FULL;
            end
          end
          state_nxt = S_DONE;
        end else begin
          // remember the lowest free usable slot
          if (!free_found_r && slot_free) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_REL: begin
        if (rel_hit) begin
          valid_nxt[rel_k[IDX_W-1:0]] = 1'b0;
          res_status_nxt = STAT_EXISTS;
          res_id_nxt     = id_r;
        end else begin
          res_status_nxt = STAT_NONE;
          res_id_nxt     = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_id_r    <= MIN_ID_RESET;
      max_id_r    <= MAX_ID_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_id_r    <= min_id_nxt;
      max_id_r    <= max_id_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    num_r        <= num_nxt;
    id_r         <= id_nxt;
    lim_r        <= lim_nxt;
    idx_r        <= idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id_out = out_id_r;

endmodule

/* hdl/sia_checker.sv */
module sia_checker
  import sia_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_id_out
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_id_out))
    else $error("result beat changed under stall");

  // no binding or a full table never carries an id
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_NONE || out_status == STAT_FULL) |-> out_id_out == 32'd0)
    else $error("id given without a binding");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind sequential_id_allocator sia_checker u_sia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_id_out (out_id_out)
);
